[rtl/rpt_pkg.sv]
package rpt_pkg;

	// Fixed widths of the word fields
	localparam int unsigned CHANNELS_DEF = 4;
	localparam int unsigned MASK_W       = 4;
	localparam int unsigned CHAN_W       = 3;
	localparam int unsigned COUNT_W      = 16;
	localparam int unsigned LEN_W        = 16;
	localparam int unsigned TIME_W       = 32;

	// Command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Request word
	typedef struct packed {
		logic                command;
		logic [CHAN_W-1:0]   channel;
		logic [COUNT_W-1:0]  pulse_count;
		logic [LEN_W-1:0]    on_time_ms;
		logic [LEN_W-1:0]    off_time_ms;
		logic [TIME_W-1:0]   now_ms;
	} req_word_t;

	// Response word
	typedef struct packed {
		logic [MASK_W-1:0] switch_on_mask;
		logic [MASK_W-1:0] switch_off_mask;
		logic [MASK_W-1:0] busy_mask;
	} rsp_word_t;

	// Per-channel outcome of one step
	typedef struct packed {
		logic sw_on;
		logic sw_off;
		logic busy;
	} chan_res_t;

endpackage

[rtl/rpt_channel.sv]
module rpt_channel #(
	parameter int unsigned IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rpt_pkg::req_word_t  req_s1,
	input  logic                commit,
	output rpt_pkg::chan_res_t  res
);

	// Train control state
	logic active_q, on_phase_q;
	logic active_d, on_phase_d;

	// Train payload, only read while active
	logic [rpt_pkg::COUNT_W-1:0] left_q, left_d, left_dec;
	logic [rpt_pkg::LEN_W-1:0]   on_len_q, on_len_d;
	logic [rpt_pkg::LEN_W-1:0]   off_len_q, off_len_d;
	logic [rpt_pkg::TIME_W-1:0]  toggle_q, toggle_d;

	logic hit, start_hit, due;

	// Decode and due check
	assign hit       = (IDX < 8) && (32'(req_s1.channel) == 32'(IDX));
	assign start_hit = (req_s1.command == rpt_pkg::CMD_START) && hit
		&& (req_s1.pulse_count != '0);
	assign due       = (req_s1.command == rpt_pkg::CMD_TICK) && active_q
		&& (req_s1.now_ms >= toggle_q);
	assign left_dec  = left_q - 1'b1;

	// Next state and switch bits
	always_comb begin
		active_d   = active_q;
		on_phase_d = on_phase_q;
		left_d     = left_q;
		on_len_d   = on_len_q;
		off_len_d  = off_len_q;
		toggle_d   = toggle_q;
		res        = '0;
		if (start_hit) begin
			active_d   = 1'b1;
			on_phase_d = 1'b1;
			left_d     = req_s1.pulse_count;
			on_len_d   = req_s1.on_time_ms;
			off_len_d  = req_s1.off_time_ms;
			toggle_d   = req_s1.now_ms + rpt_pkg::TIME_W'(req_s1.on_time_ms);
			res.sw_on  = 1'b1;
		end else if (due) begin
			if (on_phase_q) begin
				// end of on phase
				on_phase_d = 1'b0;
				toggle_d   = req_s1.now_ms + rpt_pkg::TIME_W'(off_len_q);
				res.sw_off = 1'b1;
			end else begin
				// end of off phase: one pulse done
				left_d = left_dec;
				if (left_dec == '0) begin
					active_d = 1'b0;
				end else begin
					on_phase_d = 1'b1;
					toggle_d   = req_s1.now_ms + rpt_pkg::TIME_W'(on_len_q);
					res.sw_on  = 1'b1;
				end
			end
		end
		res.busy = active_d;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			on_phase_q <= 1'b0;
		end else if (commit) begin
			active_q   <= active_d;
			on_phase_q <= on_phase_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (commit) begin
			left_q    <= left_d;
			on_len_q  <= on_len_d;
			off_len_q <= off_len_d;
			toggle_q  <= toggle_d;
		end
	end

endmodule

[rtl/relay_pulse_train_top.sv]
// Relay pulse-train generator for CHANNELS relay channels.
// Request channel (req_valid/req_ready/req): one word per tick or start
// command. A start (command 1) switches the named relay on and times its on
// phase; a tick (command 0) advances every running train whose toggle time
// has come. Starts for a channel beyond CHANNELS or with a zero count are
// ignored.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one word per request,
// in order, with the relays switched on and off in that step and the busy
// channels after it.
// Pipeline: the request word is registered on acceptance and the response
// word is registered when that request word moves on, which waits while
// the response register holds a word that has not been taken.
// Throughput is one word per cycle while the receiver takes responses; the
// channel state update in the single logic stage sets that figure.
// Reset clears all trains (nothing busy) and empties both registers.
// When the receiver stalls, the response register holds its word; the
// request register still takes one more word, and req_ready then drops
// until the response is taken.
module relay_pulse_train_top #(
	parameter int unsigned CHANNELS = rpt_pkg::CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  rpt_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rpt_pkg::rsp_word_t rsp
);

	localparam int unsigned MW = (CHANNELS > rpt_pkg::MASK_W) ? CHANNELS : rpt_pkg::MASK_W;

	logic               valid_s1, valid_s2;
	rpt_pkg::req_word_t req_s1;
	rpt_pkg::rsp_word_t rsp_s2;
	logic               advance, commit;
	logic [MW-1:0]      on_mask, off_mask, busy_mask;

	// Pipeline control
	assign advance   = !valid_s2 || rsp_ready;
	assign commit    = valid_s1 && advance;
	assign req_ready = !valid_s1 || advance;

	// Per-channel train logic
	for (genvar i = 0; i < MW; i++) begin : g_ch
		if (i < CHANNELS) begin : g_live
			rpt_pkg::chan_res_t res;
			rpt_channel #(.IDX(i)) u_ch (
				.clk    (clk),
				.arst_n (arst_n),
				.req_s1 (req_s1),
				.commit (commit),
				.res    (res)
			);
			assign on_mask[i]   = res.sw_on;
			assign off_mask[i]  = res.sw_off;
			assign busy_mask[i] = res.busy;
		end else begin : g_pad
			assign on_mask[i]   = 1'b0;
			assign off_mask[i]  = 1'b0;
			assign busy_mask[i] = 1'b0;
		end
	end

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_s2.switch_on_mask  <= on_mask[rpt_pkg::MASK_W-1:0];
			rsp_s2.switch_off_mask <= off_mask[rpt_pkg::MASK_W-1:0];
			rsp_s2.busy_mask       <= busy_mask[rpt_pkg::MASK_W-1:0];
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// A relay switched in a step belongs to a train busy after it
	a_switch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((rsp_s2.switch_on_mask & ~rsp_s2.busy_mask) == '0)
			&& ((rsp_s2.switch_off_mask & ~rsp_s2.busy_mask) == '0))
		else $error("switched relay not busy");

	// One phase change per channel per step
	a_on_off_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((rsp_s2.switch_on_mask & rsp_s2.switch_off_mask) == '0))
		else $error("relay switched on and off in one step");

	// A word that leaves the request register lands in the response register
	a_commit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> valid_s2)
		else $error("committed word lost");

	// Back-pressure only while the request register is full
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (valid_s1 && valid_s2 && !rsp_ready))
		else $error("request stalled without cause");

endmodule
